// ===== sv/ntr_pkg.sv =====
// Shared types and constants for the non-uniform trilinear resampler.
// No dependencies; imported by the top level and its port checker.
package ntr_pkg;

   localparam int VAL_W   = 32;   // Q16.16 sample and coordinate width
   localparam int FRAC_W  = 16;   // fraction bits of Q16.16
   localparam int NOUT_W  = 9;    // output size register width
   localparam int NSRC_W  = 5;    // source size register width
   localparam int NCMP_W  = 3;    // component count register width
   localparam int OUT_MAX = 256;  // largest output size per axis

   // rescaled coordinate: at most n_out * 2^16 with n_out under 2^NOUT_W
   localparam int QW    = NOUT_W + FRAC_W;
   // divider remainder: 32-bit delta times n_out, shifted by FRAC_W
   localparam int RW    = VAL_W + NOUT_W + FRAC_W;
   localparam int P_W   = VAL_W + FRAC_W + 2;
   localparam int ACC_W = P_W + 1;

   localparam logic [FRAC_W:0] ONE_Q = {1'b1, {FRAC_W{1'b0}}};

   // request opcodes
   localparam logic [1:0] OP_LOAD_COORD  = 2'd0;
   localparam logic [1:0] OP_LOAD_SAMPLE = 2'd1;
   localparam logic [1:0] OP_QUERY       = 2'd2;

   // register indexes
   localparam logic [2:0] REG_OUT_X = 3'd0;
   localparam logic [2:0] REG_OUT_Y = 3'd1;
   localparam logic [2:0] REG_OUT_Z = 3'd2;
   localparam logic [2:0] REG_SRC_X = 3'd3;
   localparam logic [2:0] REG_SRC_Y = 3'd4;
   localparam logic [2:0] REG_SRC_Z = 3'd5;
   localparam logic [2:0] REG_COMP  = 3'd6;

endpackage

// ===== sv/nonuniform_trilinear_resampler.sv =====
// Non-uniform trilinear resampler: coordinate and volume memories, shared
// bit-serial divider, sequential multiply steps for the blend. Uses ntr_pkg.
//
// Loads (coordinate or sample) leave busy low. A query holds busy while
// each axis with a nonempty range walks its coordinate memory one entry
// at a time, each rescale running the bit-serial divider after a fetch,
// and a further divide may yield the interval fraction. The eight corners
// then come from the volume memory one per cycle, and seven blends each
// pass through a multiply, a multiply-add and a rounding write-back. A
// query whose component is at or beyond component_count answers in the
// next cycle without busy.
// Each result is shown for exactly one cycle on rsp_valid and cannot be
// held off; a new item may be started in the cycle a result is shown.
module nonuniform_trilinear_resampler #(
   parameter int SRC_MAX        = 16,
   parameter int MAX_COMPONENTS = 4
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic [1:0]                        req_op,
   input  logic [1:0]                        req_axis_sel,
   input  logic [3:0]                        req_coord_index,
   input  logic [3:0]                        req_src_x,
   input  logic [3:0]                        req_src_y,
   input  logic [3:0]                        req_src_z,
   input  logic [1:0]                        req_component,
   input  logic [7:0]                        req_out_x,
   input  logic [7:0]                        req_out_y,
   input  logic [7:0]                        req_out_z,
   input  logic signed [ntr_pkg::VAL_W-1:0]  req_value,
   output logic                              rsp_valid,
   output logic signed [ntr_pkg::VAL_W-1:0]  rsp_out_value,
   output logic                              rsp_degenerate_flag,
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [4:0]                        paddr,
   input  logic [31:0]                       pwdata,
   output logic [31:0]                       prdata,
   output logic                              pready
);
   import ntr_pkg::*;

   localparam int SW        = $clog2(SRC_MAX);
   localparam int CW        = (MAX_COMPONENTS > 1) ? $clog2(MAX_COMPONENTS) : 1;
   localparam int VA_W      = 3 * SW + CW;
   localparam int CA_W      = 2 + SW;
   localparam int SRC_RST   = (SRC_MAX < 16) ? SRC_MAX : 16;
   localparam int COMP_RST  = (MAX_COMPONENTS < 3) ? MAX_COMPONENTS : 3;

   typedef enum logic [3:0] {
      ST_IDLE, ST_AX_START, ST_FETCH, ST_LOAD, ST_DIV, ST_DIV_DONE,
      ST_CORNER, ST_BL_A, ST_BL_B, ST_BL_C
   } state_type;

   // memories
   logic [VAL_W-1:0] vol_mem [1 << VA_W];
   logic [VAL_W-1:0] crd_mem [1 << CA_W];
   logic [VAL_W-1:0] vol_rd_ff;
   logic [VAL_W-1:0] crd_rd_ff;

   state_type state_ff, state_in;
   logic [1:0]               ax_ff, ax_in;
   logic [SW-1:0]            cidx_ff, cidx_in;
   logic                     first_ff, first_in;
   logic [QW-1:0]            lo_ff, lo_in;
   logic                     flag_ff, flag_in;
   logic [7:0]               pos_ff [3];
   logic [7:0]               pos_in [3];
   logic [CW-1:0]            comp_ff, comp_in;
   logic [SW-1:0]            idx_ff [3];
   logic [SW-1:0]            idx_in [3];
   logic [FRAC_W:0]          frac_ff [3];
   logic [FRAC_W:0]          frac_in [3];
   logic                     dfrac_ff, dfrac_in;
   logic [RW-1:0]            rem_ff, rem_in;
   logic [RW-1:0]            dsh_ff, dsh_in;
   logic [QW-1:0]            quo_ff, quo_in;
   logic [4:0]               dcnt_ff, dcnt_in;
   logic [3:0]               cnt_ff, cnt_in;
   logic signed [VAL_W-1:0]  w_ff [8];
   logic signed [VAL_W-1:0]  w_in [8];
   logic [1:0]               lvl_ff, lvl_in;
   logic [1:0]               k_ff, k_in;
   logic signed [P_W-1:0]    p_ff, p_in;
   logic signed [ACC_W-1:0]  acc_ff, acc_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic signed [VAL_W-1:0]  rsp_value_ff, rsp_value_in;
   logic                     rsp_flag_ff, rsp_flag_in;
   logic [NOUT_W-1:0]        osz_ff [3];
   logic [NOUT_W-1:0]        osz_in [3];
   logic [NSRC_W-1:0]        ssz_ff [3];
   logic [NSRC_W-1:0]        ssz_in [3];
   logic [NCMP_W-1:0]        ccnt_ff, ccnt_in;
   logic signed [VAL_W-1:0]  amin_ff [3];
   logic signed [VAL_W-1:0]  amin_in [3];
   logic signed [VAL_W-1:0]  amax_ff [3];
   logic signed [VAL_W-1:0]  amax_in [3];

   logic                     accept;
   logic                     coord_ok;
   logic                     sample_ok;
   logic [VA_W-1:0]          vol_waddr;
   logic [VA_W-1:0]          vol_raddr;
   logic [CA_W-1:0]          crd_waddr;
   logic [CA_W-1:0]          crd_raddr;
   logic [SW-1:0]            cx, cy, cz;
   logic                     csr_wr;

   function automatic logic signed [VAL_W-1:0] sat_val(input logic signed [ACC_W-1:0] v);
      logic signed [ACC_W-1:0] hi_lim;
      logic signed [ACC_W-1:0] lo_lim;
      hi_lim = ACC_W'({1'b0, {(VAL_W-1){1'b1}}});
      lo_lim = -hi_lim - ACC_W'(1);
      if (v > hi_lim) return {1'b0, {(VAL_W-1){1'b1}}};
      if (v < lo_lim) return {1'b1, {(VAL_W-1){1'b0}}};
      return v[VAL_W-1:0];
   endfunction

   assign busy      = (state_ff != ST_IDLE);
   assign accept    = start && !busy;
   assign pready    = 1'b1;
   assign csr_wr    = psel && penable && pwrite;
   assign rsp_valid           = rsp_valid_ff;
   assign rsp_out_value       = rsp_value_ff;
   assign rsp_degenerate_flag = rsp_flag_ff;

   assign coord_ok  = (req_axis_sel < 2'd3) && (32'(req_coord_index) < SRC_MAX);
   assign sample_ok = (32'(req_src_x) < SRC_MAX) && (32'(req_src_y) < SRC_MAX) &&
                      (32'(req_src_z) < SRC_MAX) && (32'(req_component) < MAX_COMPONENTS);
   assign crd_waddr = {req_axis_sel, SW'(req_coord_index)};
   assign vol_waddr = {SW'(req_src_z), SW'(req_src_y), SW'(req_src_x), CW'(req_component)};
   assign crd_raddr = {ax_ff, cidx_ff};
   assign cx        = idx_ff[0] + SW'(cnt_ff[0]);
   assign cy        = idx_ff[1] + SW'(cnt_ff[1]);
   assign cz        = idx_ff[2] + SW'(cnt_ff[2]);
   assign vol_raddr = {cz, cy, cx, comp_ff};

   always_ff @(posedge clock) begin
      if (accept && req_op == OP_LOAD_SAMPLE && sample_ok) begin
         vol_mem[vol_waddr] <= req_value;
      end
      vol_rd_ff <= vol_mem[vol_raddr];
   end

   always_ff @(posedge clock) begin
      if (accept && req_op == OP_LOAD_COORD && coord_ok) begin
         crd_mem[crd_waddr] <= req_value;
      end
      crd_rd_ff <= crd_mem[crd_raddr];
   end

   always_comb begin
      case (paddr[4:2])
         REG_OUT_X: prdata = 32'(osz_ff[0]);
         REG_OUT_Y: prdata = 32'(osz_ff[1]);
         REG_OUT_Z: prdata = 32'(osz_ff[2]);
         REG_SRC_X: prdata = 32'(ssz_ff[0]);
         REG_SRC_Y: prdata = 32'(ssz_ff[1]);
         REG_SRC_Z: prdata = 32'(ssz_ff[2]);
         REG_COMP:  prdata = 32'(ccnt_ff);
         default:   prdata = 32'd0;
      endcase
   end

   // configuration writes, clamped into range
   always_comb begin
      logic [NOUT_W-1:0] ov;
      logic [NSRC_W-1:0] sv;
      logic [NCMP_W-1:0] cv;
      osz_in  = osz_ff;
      ssz_in  = ssz_ff;
      ccnt_in = ccnt_ff;
      ov = pwdata[NOUT_W-1:0];
      if (ov == '0) ov = NOUT_W'(1);
      else if (32'(ov) > OUT_MAX) ov = NOUT_W'(OUT_MAX);
      sv = pwdata[NSRC_W-1:0];
      if (sv < NSRC_W'(2)) sv = NSRC_W'(2);
      else if (32'(sv) > SRC_MAX) sv = NSRC_W'(SRC_MAX);
      cv = pwdata[NCMP_W-1:0];
      if (cv == '0) cv = NCMP_W'(1);
      else if (32'(cv) > MAX_COMPONENTS) cv = NCMP_W'(MAX_COMPONENTS);
      if (csr_wr) begin
         unique case (paddr[4:2])
            REG_OUT_X: osz_in[0] = ov;
            REG_OUT_Y: osz_in[1] = ov;
            REG_OUT_Z: osz_in[2] = ov;
            REG_SRC_X: ssz_in[0] = sv;
            REG_SRC_Y: ssz_in[1] = sv;
            REG_SRC_Z: ssz_in[2] = sv;
            REG_COMP:  ccnt_in   = cv;
            default:   ;
         endcase
      end
   end

   // query sequencer
   always_comb begin
      logic [NOUT_W-1:0]        n_out;
      logic [NSRC_W-1:0]        n_src;
      logic signed [VAL_W-1:0]  a_min;
      logic signed [VAL_W:0]    range;
      logic [VAL_W-1:0]         delta;
      logic [VAL_W+NOUT_W-1:0]  scaled;
      logic [QW-1:0]            s_pos;
      logic signed [QW:0]       den;
      logic signed [QW:0]       num;
      logic [FRAC_W:0]          f;
      logic signed [ACC_W-1:0]  rnd;
      logic signed [VAL_W-1:0]  blend;
      logic                     next_ax;
      logic                     last_k;

      state_in     = state_ff;
      ax_in        = ax_ff;
      cidx_in      = cidx_ff;
      first_in     = first_ff;
      lo_in        = lo_ff;
      flag_in      = flag_ff;
      pos_in       = pos_ff;
      comp_in      = comp_ff;
      idx_in       = idx_ff;
      frac_in      = frac_ff;
      dfrac_in     = dfrac_ff;
      rem_in       = rem_ff;
      dsh_in       = dsh_ff;
      quo_in       = quo_ff;
      dcnt_in      = dcnt_ff;
      cnt_in       = cnt_ff;
      w_in         = w_ff;
      lvl_in       = lvl_ff;
      k_in         = k_ff;
      p_in         = p_ff;
      acc_in       = acc_ff;
      amin_in      = amin_ff;
      amax_in      = amax_ff;
      rsp_valid_in = 1'b0;
      rsp_value_in = rsp_value_ff;
      rsp_flag_in  = rsp_flag_ff;
      next_ax      = 1'b0;

      n_out  = osz_ff[ax_ff];
      n_src  = ssz_ff[ax_ff];
      a_min  = amin_ff[ax_ff];
      range  = $signed({amax_ff[ax_ff][VAL_W-1], amax_ff[ax_ff]}) -
               $signed({a_min[VAL_W-1], a_min});
      delta  = crd_rd_ff - a_min;
      scaled = (VAL_W+NOUT_W)'(delta) * (VAL_W+NOUT_W)'(n_out);
      s_pos  = QW'({pos_ff[ax_ff], {FRAC_W{1'b0}}});
      den    = $signed({1'b0, quo_ff}) - $signed({1'b0, lo_ff});
      num    = $signed({1'b0, s_pos}) - $signed({1'b0, lo_ff});
      f      = frac_ff[lvl_ff];
      rnd    = (acc_ff + ACC_W'(32768)) >>> FRAC_W;
      blend  = sat_val(rnd);
      last_k = (k_ff == 2'(3 >> lvl_ff));

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (req_op)
                  OP_LOAD_COORD: begin
                     if (coord_ok) begin
                        if (req_value < amin_ff[req_axis_sel]) amin_in[req_axis_sel] = req_value;
                        if (req_value > amax_ff[req_axis_sel]) amax_in[req_axis_sel] = req_value;
                     end
                  end
                  OP_QUERY: begin
                     if ({1'b0, req_component} >= ccnt_ff) begin
                        rsp_valid_in = 1'b1;
                        rsp_value_in = '0;
                        rsp_flag_in  = 1'b1;
                     end else begin
                        pos_in[0] = req_out_x;
                        pos_in[1] = req_out_y;
                        pos_in[2] = req_out_z;
                        comp_in   = CW'(req_component);
                        flag_in   = 1'b0;
                        ax_in     = 2'd0;
                        state_in  = ST_AX_START;
                     end
                  end
                  default: ;
               endcase
            end
         end
         ST_AX_START: begin
            if (range <= 0) begin
               // empty range: interval 0, fraction 0
               flag_in        = 1'b1;
               idx_in[ax_ff]  = '0;
               frac_in[ax_ff] = '0;
               next_ax        = 1'b1;
            end else begin
               cidx_in  = '0;
               first_in = 1'b1;
               state_in = ST_FETCH;
            end
         end
         ST_FETCH: state_in = ST_LOAD;
         ST_LOAD: begin
            rem_in   = RW'(scaled) << FRAC_W;
            dsh_in   = RW'(range[VAL_W-1:0]) << (QW - 1);
            quo_in   = '0;
            dcnt_in  = 5'(QW - 1);
            dfrac_in = 1'b0;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            if (rem_ff >= dsh_ff) begin
               rem_in = rem_ff - dsh_ff;
               quo_in = {quo_ff[QW-2:0], 1'b1};
            end else begin
               quo_in = {quo_ff[QW-2:0], 1'b0};
            end
            dsh_in = dsh_ff >> 1;
            if (dcnt_ff == '0) state_in = ST_DIV_DONE;
            else dcnt_in = dcnt_ff - 5'd1;
         end
         ST_DIV_DONE: begin
            if (dfrac_ff) begin
               frac_in[ax_ff] = (FRAC_W+1)'(quo_ff);
               next_ax        = 1'b1;
            end else if (first_ff) begin
               lo_in    = quo_ff;
               first_in = 1'b0;
               cidx_in  = cidx_ff + SW'(1);
               state_in = ST_FETCH;
            end else if (s_pos <= quo_ff) begin
               idx_in[ax_ff] = cidx_ff - SW'(1);
               if (den <= 0) begin
                  flag_in        = 1'b1;
                  frac_in[ax_ff] = '0;
                  next_ax        = 1'b1;
               end else if (num <= 0) begin
                  frac_in[ax_ff] = '0;
                  next_ax        = 1'b1;
               end else if (num >= den) begin
                  frac_in[ax_ff] = ONE_Q;
                  next_ax        = 1'b1;
               end else begin
                  rem_in   = RW'(num[QW-1:0]) << FRAC_W;
                  dsh_in   = RW'(den[QW-1:0]) << (FRAC_W - 1);
                  quo_in   = '0;
                  dcnt_in  = 5'(FRAC_W - 1);
                  dfrac_in = 1'b1;
                  state_in = ST_DIV;
               end
            end else begin
               lo_in = quo_ff;
               if (32'(cidx_ff) == 32'(n_src) - 1) begin
                  // past the grid: last interval, fraction 1
                  idx_in[ax_ff]  = SW'(n_src - NSRC_W'(2));
                  frac_in[ax_ff] = ONE_Q;
                  next_ax        = 1'b1;
               end else begin
                  cidx_in  = cidx_ff + SW'(1);
                  state_in = ST_FETCH;
               end
            end
         end
         ST_CORNER: begin
            // read data is registered and trails its address into the next cycle
            if (cnt_ff != 4'd0) w_in[3'(cnt_ff - 4'd1)] = vol_rd_ff;
            if (cnt_ff == 4'd8) begin
               lvl_in   = 2'd0;
               k_in     = 2'd0;
               state_in = ST_BL_A;
            end else begin
               cnt_in = cnt_ff + 4'd1;
            end
         end
         ST_BL_A: begin
            p_in     = P_W'(w_ff[{k_ff, 1'b0}]) * P_W'($signed({1'b0, ONE_Q - f}));
            state_in = ST_BL_B;
         end
         ST_BL_B: begin
            acc_in   = ACC_W'(p_ff) + ACC_W'(w_ff[{k_ff, 1'b1}]) * ACC_W'($signed({1'b0, f}));
            state_in = ST_BL_C;
         end
         ST_BL_C: begin
            w_in[3'(k_ff)] = blend;
            if (!last_k) begin
               k_in     = k_ff + 2'd1;
               state_in = ST_BL_A;
            end else if (lvl_ff == 2'd2) begin
               rsp_valid_in = 1'b1;
               rsp_value_in = blend;
               rsp_flag_in  = flag_ff;
               state_in     = ST_IDLE;
            end else begin
               lvl_in   = lvl_ff + 2'd1;
               k_in     = 2'd0;
               state_in = ST_BL_A;
            end
         end
         default: state_in = ST_IDLE;
      endcase

      if (next_ax) begin
         if (ax_ff == 2'd2) begin
            cnt_in   = 4'd0;
            state_in = ST_CORNER;
         end else begin
            ax_in    = ax_ff + 2'd1;
            state_in = ST_AX_START;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         for (int a = 0; a < 3; a++) begin
            osz_ff[a]  <= NOUT_W'(OUT_MAX);
            ssz_ff[a]  <= NSRC_W'(SRC_RST);
            amin_ff[a] <= {1'b0, {(VAL_W-1){1'b1}}};
            amax_ff[a] <= {1'b1, {(VAL_W-1){1'b0}}};
         end
         ccnt_ff <= NCMP_W'(COMP_RST);
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         osz_ff       <= osz_in;
         ssz_ff       <= ssz_in;
         amin_ff      <= amin_in;
         amax_ff      <= amax_in;
         ccnt_ff      <= ccnt_in;
      end
      ax_ff        <= ax_in;
      cidx_ff      <= cidx_in;
      first_ff     <= first_in;
      lo_ff        <= lo_in;
      flag_ff      <= flag_in;
      pos_ff       <= pos_in;
      comp_ff      <= comp_in;
      idx_ff       <= idx_in;
      frac_ff      <= frac_in;
      dfrac_ff     <= dfrac_in;
      rem_ff       <= rem_in;
      dsh_ff       <= dsh_in;
      quo_ff       <= quo_in;
      dcnt_ff      <= dcnt_in;
      cnt_ff       <= cnt_in;
      w_ff         <= w_in;
      lvl_ff       <= lvl_in;
      k_ff         <= k_in;
      p_ff         <= p_in;
      acc_ff       <= acc_in;
      rsp_value_ff <= rsp_value_in;
      rsp_flag_ff  <= rsp_flag_in;
   end

endmodule

// ===== sv/ntr_checker.sv =====
// Port-level checks for the non-uniform trilinear resampler.
// Uses ntr_pkg; bound to the top level at the end of this file.
module ntr_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              start,
   input logic                              busy,
   input logic [1:0]                        req_op,
   input logic                              rsp_valid,
   input logic signed [ntr_pkg::VAL_W-1:0]  rsp_out_value,
   input logic                              rsp_degenerate_flag
);
   import ntr_pkg::*;

   // loads finish in the cycle they are taken
   a_load_no_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_op != OP_QUERY) |=> !busy)
      else $error("load left the block busy");

   a_query_progress: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_op == OP_QUERY) |=> (busy || rsp_valid))
      else $error("query neither started nor answered");

   a_word_when_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result word shown while busy");

   a_busy_ends_word: assert property (@(posedge clock) disable iff (reset)
      $fell(busy) |-> rsp_valid)
      else $error("query ended without a result word");

   a_bad_comp_value: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && $past(start && !busy && req_op == OP_QUERY)) |->
      (rsp_degenerate_flag && rsp_out_value == '0))
      else $error("immediate answer is not the rejected-component word");

endmodule

bind nonuniform_trilinear_resampler ntr_checker u_ntr_checker (.*);
